@@ rtl/core/fes_pkg.sv @@
// Shared constants and float helpers for the exact float summation block.
// Used by fes_fadd and exact_float_sum; no dependencies.
package fes_pkg;

  localparam int unsigned MaxPartialsDef = 16;
  localparam logic [31:0] FZero    = 32'h0000_0000;
  localparam logic [31:0] FQuiet   = 32'h0040_0000;
  localparam logic [31:0] FDefNan  = 32'hffc0_0000;

  // NaN: all-ones exponent and nonzero fraction
  function automatic logic f_is_nan(input logic [31:0] v);
    return (v[30:23] == 8'hff) && (v[22:0] != 23'd0);
  endfunction

  function automatic logic f_is_inf(input logic [31:0] v);
    return (v[30:23] == 8'hff) && (v[22:0] == 23'd0);
  endfunction

  // Both signed zeros compare equal to zero
  function automatic logic f_is_zero(input logic [31:0] v);
    return v[30:0] == 31'd0;
  endfunction

  // |a| < |b|, false when either is NaN
  function automatic logic f_mag_lt(input logic [31:0] a, input logic [31:0] b);
    return !f_is_nan(a) && !f_is_nan(b) && (a[30:0] < b[30:0]);
  endfunction

  function automatic logic f_is_pos(input logic [31:0] v);
    return !v[31] && !f_is_zero(v) && !f_is_nan(v);
  endfunction

  function automatic logic f_is_neg(input logic [31:0] v);
    return v[31] && !f_is_zero(v) && !f_is_nan(v);
  endfunction

  // Float equality: zeros match regardless of sign, NaN never matches
  function automatic logic f_eq(input logic [31:0] a, input logic [31:0] b);
    return !f_is_nan(a) && !f_is_nan(b) &&
           ((a == b) || (f_is_zero(a) && f_is_zero(b)));
  endfunction

endpackage

@@ rtl/core/fes_fadd.sv @@
// Two-stage single-precision adder, round to nearest even, with subnormals.
// Depends on fes_pkg. Result is valid in the cycle after the operands.
module fes_fadd (
  input  logic        clk_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic        sub_i,
  output logic [31:0] res_o
);
  import fes_pkg::*;

  logic [31:0] bn;
  logic [31:0] big, sml;
  logic        spec;
  logic [31:0] spec_val;
  logic [7:0]  eb, es, d;
  logic [26:0] mbig, msml, mal;
  logic [53:0] shv;
  logic        sticky;
  logic [27:0] sum;

  logic        spec_q, sign_q, zs_q;
  logic [31:0] spec_val_q;
  logic [7:0]  e_q;
  logic [27:0] sum_q;

  // Stage 1: specials, swap, align and add
  always_comb begin
    bn = sub_i ? {~b_i[31], b_i[30:0]} : b_i;
    spec = 1'b1;
    spec_val = FZero;
    if (f_is_nan(a_i)) begin
      spec_val = a_i | FQuiet;
    end else if (f_is_nan(b_i)) begin
      spec_val = b_i | FQuiet;
    end else if (f_is_inf(a_i) && f_is_inf(bn) && (a_i[31] != bn[31])) begin
      spec_val = FDefNan;
    end else if (f_is_inf(a_i)) begin
      spec_val = a_i;
    end else if (f_is_inf(bn)) begin
      spec_val = bn;
    end else begin
      spec = 1'b0;
    end
    if (bn[30:0] > a_i[30:0]) begin
      big = bn;
      sml = a_i;
    end else begin
      big = a_i;
      sml = bn;
    end
    eb = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    es = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    mbig = {big[30:23] != 8'd0, big[22:0], 3'b000};
    msml = {sml[30:23] != 8'd0, sml[22:0], 3'b000};
    d = eb - es;
    shv = {msml, 27'd0} >> d;
    if (d >= 8'd27) begin
      mal = {26'd0, |msml};
    end else begin
      sticky = |shv[26:0];
      mal = {shv[53:28], shv[27] | sticky};
    end
    sticky = |shv[26:0];
    if (big[31] != sml[31]) begin
      sum = {1'b0, mbig} - {1'b0, mal};
    end else begin
      sum = {1'b0, mbig} + {1'b0, mal};
    end
  end

  always_ff @(posedge clk_i) begin
    spec_q     <= spec;
    spec_val_q <= spec_val;
    sign_q     <= big[31];
    zs_q       <= a_i[31] & bn[31];
    e_q        <= eb;
    sum_q      <= sum;
  end

  // Stage 2: normalize and round
  logic [4:0]  lz, sh;
  logic [8:0]  e1;
  logic [26:0] s1;
  logic        up;
  logic [24:0] rv;
  logic [8:0]  e2;
  logic [7:0]  field;

  always_comb begin
    lz = 5'd0;
    for (int i = 0; i < 27; i++) begin
      if (sum_q[i]) lz = 5'(26 - i);
    end
    if (sum_q[27]) begin
      s1 = {sum_q[27:2], sum_q[1] | sum_q[0]};
      e1 = {1'b0, e_q} + 9'd1;
      sh = 5'd0;
    end else begin
      sh = ({4'd0, lz} < ({1'b0, e_q} - 9'd1)) ? lz : 5'((e_q - 8'd1));
      s1 = sum_q[26:0] << sh;
      e1 = {1'b0, e_q} - {4'd0, sh};
    end
    up = s1[2] & (s1[1] | s1[0] | s1[3]);
    rv = {1'b0, s1[26:3]} + {24'd0, up};
    if (rv[24]) begin
      e2 = e1 + 9'd1;
      rv = {1'b0, rv[24:1]};
    end else begin
      e2 = e1;
    end
    field = rv[23] ? e2[7:0] : 8'd0;
    if (spec_q) begin
      res_o = spec_val_q;
    end else if (sum_q == 28'd0) begin
      res_o = {zs_q, 31'd0};
    end else if (e2 >= 9'd255) begin
      res_o = {sign_q, 8'hff, 23'd0};
    end else begin
      res_o = {sign_q, field, rv[22:0]};
    end
  end

endmodule

@@ rtl/core/exact_float_sum.sv @@
// Exact float summation: store of non-overlapping partials, correctly rounded sum.
// Depends on fes_pkg and fes_fadd.
//
//  channel | direction | signals                          | handshake
//  --------+-----------+----------------------------------+-------------------------
//  in      | input     | value_bits_i, last_value_i        | in_valid_i / in_ready_o
//  out     | output    | sum_bits_o, store_overflow_o      | out_valid_o / out_ready_i
//
// Every float addition and subtraction goes through one shared two-stage adder.
// Merging one value into the partials takes three adds and a store read per
// partial; the last value then adds a fold over the partials, at most a read and
// three adds per partial, and a rounding correction of a read and three more adds.
// Reset clears the partial count, the overflow flag and all handshake state.
// A result waiting on out_ready_i holds the block in its output state.
module exact_float_sum #(
  parameter int unsigned MAX_PARTIALS = fes_pkg::MaxPartialsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] value_bits_i,
  input  logic        last_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] sum_bits_o,
  output logic        store_overflow_o
);
  import fes_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_PARTIALS + 1);
  localparam int unsigned IdxW = $clog2(MAX_PARTIALS);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_PARTIALS);
  localparam logic [IdxW-1:0] IdxTop = IdxW'(MAX_PARTIALS - 1);

  localparam logic [4:0] S_IDLE = 5'd0,  S_MRD = 5'd1,  S_MHI = 5'd2,  S_MPT = 5'd3,
                         S_MLO  = 5'd4,  S_APP = 5'd5,  S_TOP = 5'd6,  S_FIN = 5'd7,
                         S_FRD  = 5'd8,  S_FHI = 5'd9,  S_FPT = 5'd10, S_FLO = 5'd11,
                         S_CRD  = 5'd12, S_CY  = 5'd13, S_CX  = 5'd14, S_CP  = 5'd15,
                         S_OUT  = 5'd16;

  logic [4:0]      state_q;
  logic            ph_q;
  logic [CntW-1:0] count_q, k_q, keep_q;
  logic            ovf_q, last_q;
  logic [31:0]     x_q, y_q, big_q, small_q, hi_q, part_q, lo_q;
  logic            out_valid_q, out_ovf_q;
  logic [31:0]     out_sum_q;

  logic [31:0] store_q [MAX_PARTIALS];
  logic [IdxW-1:0] rd_idx, wr_idx;
  logic [31:0]     rd_data, wr_data;
  logic            wr_en;

  logic [31:0] add_a, add_b, add_res;
  logic        add_sub;

  fes_fadd u_fadd (
    .clk_i (clk_i),
    .a_i   (add_a),
    .b_i   (add_b),
    .sub_i (add_sub),
    .res_o (add_res)
  );

  // Select the store entry to read
  always_comb begin
    case (state_q)
      S_TOP:        rd_idx = IdxTop;
      S_FIN:        rd_idx = IdxW'(count_q - CntW'(1));
      S_FRD, S_CRD: rd_idx = IdxW'(k_q - CntW'(1));
      default:      rd_idx = k_q[IdxW-1:0];
    endcase
  end
  assign rd_data = store_q[rd_idx];

  // Route adder operands
  always_comb begin
    add_a = hi_q;
    add_b = big_q;
    add_sub = 1'b0;
    case (state_q)
      S_MHI: begin add_a = big_q;   add_b = small_q; end
      S_MPT: begin add_a = hi_q;    add_b = big_q;  add_sub = 1'b1; end
      S_MLO: begin add_a = small_q; add_b = part_q; add_sub = 1'b1; end
      S_TOP: begin add_a = rd_data; add_b = x_q; end
      S_FHI: begin add_a = x_q;     add_b = y_q; end
      S_FPT: begin add_a = hi_q;    add_b = x_q;    add_sub = 1'b1; end
      S_FLO: begin add_a = y_q;     add_b = part_q; add_sub = 1'b1; end
      S_CY:  begin add_a = lo_q;    add_b = lo_q; end
      S_CX:  begin add_a = hi_q;    add_b = y_q; end
      S_CP:  begin add_a = x_q;     add_b = hi_q;   add_sub = 1'b1; end
      default: ;
    endcase
  end

  // Store writes: kept error terms, appended value, overflow into the top
  always_comb begin
    wr_en = 1'b0;
    wr_idx = keep_q[IdxW-1:0];
    wr_data = x_q;
    case (state_q)
      S_MLO: begin
        wr_en = ph_q && !f_is_zero(add_res);
        wr_data = add_res;
      end
      S_APP: wr_en = !f_is_zero(x_q) && (keep_q != CntMax);
      S_TOP: begin
        wr_en = ph_q;
        wr_idx = IdxTop;
        wr_data = add_res;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_idx] <= wr_data;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ph_q <= 1'b0;
      count_q <= '0;
      k_q <= '0;
      keep_q <= '0;
      ovf_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // Drop the result after its transfer; the output state refills it itself
      if (out_valid_q && out_ready_i && (state_q != S_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            x_q <= value_bits_i;
            last_q <= last_value_i;
            k_q <= '0;
            keep_q <= '0;
            state_q <= S_MRD;
          end
        end
        S_MRD: begin
          if (k_q < count_q) begin
            if (f_mag_lt(x_q, rd_data)) begin
              big_q <= rd_data;
              small_q <= x_q;
            end else begin
              big_q <= x_q;
              small_q <= rd_data;
            end
            state_q <= S_MHI;
          end else begin
            state_q <= S_APP;
          end
        end
        S_MHI: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            hi_q <= add_res;
            state_q <= S_MPT;
          end
        end
        S_MPT: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            part_q <= add_res;
            state_q <= S_MLO;
          end
        end
        S_MLO: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            if (!f_is_zero(add_res)) keep_q <= keep_q + CntW'(1);
            x_q <= hi_q;
            k_q <= k_q + CntW'(1);
            state_q <= S_MRD;
          end
        end
        S_APP: begin
          if (!f_is_zero(x_q) && keep_q == CntMax) begin
            count_q <= keep_q;
            state_q <= S_TOP;
          end else begin
            count_q <= f_is_zero(x_q) ? keep_q : keep_q + CntW'(1);
            state_q <= last_q ? S_FIN : S_IDLE;
          end
        end
        S_TOP: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            ovf_q <= 1'b1;
            state_q <= last_q ? S_FIN : S_IDLE;
          end
        end
        S_FIN: begin
          if (count_q == '0) begin
            hi_q <= FZero;
            state_q <= S_OUT;
          end else begin
            hi_q <= rd_data;
            k_q <= count_q - CntW'(1);
            state_q <= S_FRD;
          end
        end
        S_FRD: begin
          if (k_q != '0) begin
            y_q <= rd_data;
            x_q <= hi_q;
            k_q <= k_q - CntW'(1);
            state_q <= S_FHI;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_FHI: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            hi_q <= add_res;
            state_q <= S_FPT;
          end
        end
        S_FPT: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            part_q <= add_res;
            state_q <= S_FLO;
          end
        end
        S_FLO: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            lo_q <= add_res;
            state_q <= f_is_zero(add_res) ? S_FRD : S_CRD;
          end
        end
        S_CRD: begin
          if (k_q != '0 && ((f_is_neg(lo_q) && f_is_neg(rd_data)) ||
                            (f_is_pos(lo_q) && f_is_pos(rd_data)))) begin
            state_q <= S_CY;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_CY: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            y_q <= add_res;
            state_q <= S_CX;
          end
        end
        S_CX: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            x_q <= add_res;
            state_q <= S_CP;
          end
        end
        S_CP: begin
          ph_q <= !ph_q;
          if (ph_q) begin
            if (f_eq(y_q, add_res)) hi_q <= x_q;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          // Hold until the output register is free, then clear the store
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            out_sum_q <= hi_q;
            out_ovf_q <= ovf_q;
            count_q <= '0;
            ovf_q <= 1'b0;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign sum_bits_o = out_sum_q;
  assign store_overflow_o = out_ovf_q;

  // The store never holds more than its capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= CntMax)
    else $error("partial count beyond capacity");

  // A new result leaves the store cleared for the next list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> (count_q == '0) && !ovf_q)
    else $error("store not cleared with result");

  // An accepted value blocks further input while it is merged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken during merge");

endmodule

@@ dv/exact_float_sum_tb.sv @@
// Testbench for exact_float_sum: random and directed float lists against a bit-exact
// software model of the partial-sum store. Depends on exact_float_sum (and fes_pkg).
`timescale 1ns / 1ps

module exact_float_sum_tb;

  localparam int unsigned NumParts = 16;
  localparam logic [31:0] DefNan   = 32'hffc0_0000;
  localparam logic [31:0] FTwo     = 32'h4000_0000;
  localparam logic [31:0] FOne     = 32'h3f80_0000;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
  } value_t;

  typedef struct packed {
    logic [31:0] sum;
    logic        ovf;
  } sum_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] value_bits_i = '0;
  logic        last_value_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] sum_bits_o;
  logic        store_overflow_o;

  value_t      pending_q[$];
  sum_t        sums_q[$];
  int          err_cnt = 0;
  bit          stim_done = 1'b0;

  // model state
  logic [31:0] parts[NumParts];
  int          part_cnt = 0;
  bit          ovf_seen = 1'b0;

  exact_float_sum u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .value_bits_i, .last_value_i,
    .out_valid_o, .out_ready_i, .sum_bits_o, .store_overflow_o
  );

  always #6 clk_i = ~clk_i;

  function automatic bit is_nan(logic [31:0] v);
    return v[30:23] == 8'hff && v[22:0] != 0;
  endfunction

  function automatic bit is_zero(logic [31:0] v);
    return v[30:0] == 0;
  endfunction

  function automatic bit mag_less(logic [31:0] a, logic [31:0] b);
    return !is_nan(a) && !is_nan(b) && a[30:0] < b[30:0];
  endfunction

  function automatic bit feq(logic [31:0] a, logic [31:0] b);
    return !is_nan(a) && !is_nan(b) && (a == b || (is_zero(a) && is_zero(b)));
  endfunction

  // IEEE single add, round to nearest even
  function automatic logic [31:0] fadd(logic [31:0] a, logic [31:0] b);
    logic [31:0] t;
    logic [23:0] ma, mb;
    logic [63:0] wb;
    logic [27:0] sa, sb, s;
    logic [24:0] mant;
    int          ea, eb, d, e;
    bit          rnd;
    if (is_nan(a) || is_nan(b)) return DefNan;
    if (a[30:23] == 8'hff && b[30:23] == 8'hff) return (a[31] != b[31]) ? DefNan : a;
    if (a[30:23] == 8'hff) return a;
    if (b[30:23] == 8'hff) return b;
    if (is_zero(a) && is_zero(b)) return {a[31] & b[31], 31'd0};
    if (is_zero(a)) return b;
    if (is_zero(b)) return a;
    if (a[30:0] < b[30:0]) begin
      t = a; a = b; b = t;
    end
    ea = (a[30:23] == 0) ? 1 : a[30:23];
    eb = (b[30:23] == 0) ? 1 : b[30:23];
    ma = {a[30:23] != 0, a[22:0]};
    mb = {b[30:23] != 0, b[22:0]};
    d = ea - eb;
    sa = {1'b0, ma, 3'b000};
    wb = {37'd0, mb, 3'b000};
    if (d > 26) sb = {27'd0, |wb};
    else sb = 28'(wb >> d) | 28'(|(wb & ((64'd1 << d) - 1)));
    s = (a[31] == b[31]) ? sa + sb : sa - sb;
    // exact cancellation rounds to +0
    if (s == 0) return 32'h0;
    e = ea;
    // normalize
    if (s[27]) begin
      s = (s >> 1) | 28'(s[0]);
      e++;
    end else begin
      while (!s[26] && e > 1) begin
        s = s << 1;
        e--;
      end
    end
    mant = {1'b0, s[26:3]};
    rnd = s[2] && (s[1] || s[0] || s[3]);
    if (rnd) mant = mant + 1;
    if (mant[24]) begin
      mant = mant >> 1;
      e++;
    end
    if (e >= 255) return {a[31], 8'hff, 23'd0};
    if (!mant[23]) return {a[31], 8'd0, mant[22:0]};
    return {a[31], 8'(e), mant[22:0]};
  endfunction

  function automatic logic [31:0] fsub(logic [31:0] a, logic [31:0] b);
    return fadd(a, {~b[31], b[30:0]});
  endfunction

  // lo * 2.0, lo finite and nonzero here
  function automatic logic [31:0] fmul2(logic [31:0] v);
    return fadd(v, v);
  endfunction

  // Merge one value into the partial store
  task automatic merge_value(logic [31:0] x);
    int          keep;
    logic [31:0] y, big, sml, hi, part, lo;
    keep = 0;
    for (int k = 0; k < part_cnt; k++) begin
      y = parts[k];
      if (mag_less(x, y)) begin
        big = y; sml = x;
      end else begin
        big = x; sml = y;
      end
      hi = fadd(big, sml);
      part = fsub(hi, big);
      lo = fsub(sml, part);
      if (!is_zero(lo)) begin
        parts[keep] = lo;
        keep++;
      end
      x = hi;
    end
    part_cnt = keep;
    if (!is_zero(x)) begin
      if (part_cnt >= NumParts) begin
        parts[NumParts-1] = fadd(parts[NumParts-1], x);
        ovf_seen = 1'b1;
      end else begin
        parts[part_cnt] = x;
        part_cnt++;
      end
    end
  endtask

  // Fold partials from the top and apply the half-way correction
  function automatic logic [31:0] fold_sum();
    int          n;
    logic [31:0] hi, lo, xv, yv, part, below;
    n = part_cnt;
    lo = 32'h0;
    if (n == 0) return 32'h0;
    n--;
    hi = parts[n];
    while (n > 0) begin
      xv = hi;
      n--;
      yv = parts[n];
      hi = fadd(xv, yv);
      part = fsub(hi, xv);
      lo = fsub(yv, part);
      if (!is_zero(lo)) break;
    end
    if (n > 0) begin
      below = parts[n-1];
      if (!is_nan(lo) && !is_nan(below) && !is_zero(lo) && !is_zero(below) &&
          lo[31] == below[31]) begin
        yv = fmul2(lo);
        xv = fadd(hi, yv);
        part = fsub(xv, hi);
        if (feq(yv, part)) hi = xv;
      end
    end
    return hi;
  endfunction

  task automatic push_value(logic [31:0] v, bit last);
    value_t it;
    it.value = v;
    it.last = last;
    pending_q.push_back(it);
  endtask

  function automatic logic [31:0] rand_float();
    int          pick;
    logic [7:0]  ex;
    pick = $urandom_range(0, 99);
    if (pick < 70) ex = 8'($urandom_range(110, 140));
    else if (pick < 90) ex = 8'($urandom_range(0, 254));
    else if (pick < 94) ex = 8'h00;
    else if (pick < 97) ex = 8'hfe;
    else ex = 8'hff;
    if (pick >= 98) return {$urandom_range(0, 1) == 1, 31'd0};
    return {$urandom_range(0, 1) == 1, ex, 23'($urandom)};
  endfunction

  // Reset and stimulus
  initial begin
    logic [31:0] lst[$];
    int          len;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed lists
    push_value(32'h0000_0000, 1'b1);
    push_value(32'h8000_0000, 1'b1);
    push_value(32'h7f7f_ffff, 1'b0);
    push_value(32'h7f7f_ffff, 1'b1);
    push_value(32'h0000_0001, 1'b0);
    push_value(32'h8000_0001, 1'b0);
    push_value(32'hffff_ffff, 1'b1);
    push_value(32'h7f80_0000, 1'b0);
    push_value(32'hff80_0000, 1'b1);
    push_value(32'h7fc0_0000, 1'b1);
    push_value(FOne, 1'b0);
    push_value(32'h3380_0000, 1'b0);
    push_value(32'h21c0_0000, 1'b1);
    push_value(FOne, 1'b0);
    push_value(32'hb380_0000, 1'b0);
    push_value(32'ha1c0_0000, 1'b1);
    push_value(FTwo, 1'b0);
    push_value(32'h2000_0000, 1'b0);
    push_value(32'hc000_0000, 1'b1);
    for (int k = 0; k < 20; k++) push_value({1'b0, 8'(250 - 12 * k), 23'h7ff001}, k == 19);
    // random lists, some with cancelling terms
    while (pending_q.size() < 780) begin
      len = $urandom_range(1, 20);
      lst.delete();
      for (int k = 0; k < len; k++) begin
        if (lst.size() > 0 && $urandom_range(0, 4) == 0)
          lst.push_back(lst[$urandom_range(0, lst.size() - 1)] ^ 32'h8000_0000);
        else
          lst.push_back(rand_float());
      end
      foreach (lst[k]) push_value(lst[k], k == len - 1);
    end
    stim_done = 1'b1;
  end

  // Drive the input channel
  int in_idle = 0;
  always @(posedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_ready_o)) begin
      if (in_idle > 0) begin
        in_idle <= in_idle - 1;
        in_valid_i <= 1'b0;
      end else if (pending_q.size() > 0 &&
                   !(pending_q.size() > 60 && $urandom_range(0, 15) == 0)) begin
        in_valid_i <= 1'b1;
        value_bits_i <= pending_q[0].value;
        last_value_i <= pending_q[0].last;
        void'(pending_q.pop_front());
      end else begin
        in_valid_i <= 1'b0;
        if (pending_q.size() > 60) in_idle <= $urandom_range(1, 18);
      end
    end
  end

  // Predict sums on each input transfer
  always @(posedge clk_i) begin
    sum_t r;
    if (rst_ni && in_valid_i && in_ready_o) begin
      merge_value(value_bits_i);
      if (last_value_i) begin
        r.sum = fold_sum();
        r.ovf = ovf_seen;
        sums_q.push_back(r);
        part_cnt = 0;
        ovf_seen = 1'b0;
      end
    end
  end

  // Stall the output channel in bursts
  int out_idle = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_idle > 0) begin
        out_idle <= out_idle - 1;
        out_ready_i <= 1'b0;
      end else if (pending_q.size() > 60 && $urandom_range(0, 9) == 0) begin
        out_idle <= $urandom_range(1, 18);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Check each output transfer
  always @(posedge clk_i) begin
    sum_t x;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (sums_q.size() == 0) begin
        $error("unexpected sum_bits %h", sum_bits_o);
        err_cnt++;
      end else begin
        x = sums_q.pop_front();
        if (!(x.sum == sum_bits_o || (is_nan(x.sum) && is_nan(sum_bits_o)))) begin
          $error("sum_bits expected %h actual %h", x.sum, sum_bits_o);
          err_cnt++;
        end
        if (x.ovf != store_overflow_o) begin
          $error("store_overflow expected %0d actual %0d", x.ovf, store_overflow_o);
          err_cnt++;
        end
      end
    end
  end

  // Drain, then report
  initial begin
    wait (stim_done);
    while (pending_q.size() > 0 || in_valid_i || sums_q.size() > 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (sums_q.size() > 0) err_cnt++;
    if (err_cnt == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #30ms;
    $display("FAILURE");
    $finish;
  end

endmodule
